[src/hfft_pkg.sv]
// ----------------------------------------------------------------------------
// hfft_pkg
// Shared types, codes and the twiddle table builder for the 3-D
// hypercomplex FFT unit.
// ----------------------------------------------------------------------------
package hfft_pkg;

   localparam int MAX_LOG_TOTAL = 12;
   localparam int PART_WIDTH    = 32;
   localparam int TWIDDLE_FRAC  = 16;
   localparam int NUM_PARTS     = 8;

   localparam int ADDR_W    = MAX_LOG_TOTAL;
   localparam int DEPTH     = 1 << MAX_LOG_TOTAL;
   localparam int LOG_W     = 4;
   localparam int TW_IDX_W  = MAX_LOG_TOTAL - 1;     // angle index, pi/2^11 steps
   localparam int ROM_DEPTH = (1 << (TW_IDX_W - 2)) + 1;
   localparam int ROM_AW    = TW_IDX_W - 1;
   localparam int TW_MAG_W  = TWIDDLE_FRAC + 1;      // magnitude up to 1.0
   localparam int TW_W      = TWIDDLE_FRAC + 2;      // signed twiddle
   localparam int PROD_W    = PART_WIDTH + TW_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int WD_W      = SUM_W - TWIDDLE_FRAC;
   localparam int RES_W     = WD_W + 1;

   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
   localparam logic [63:0] Q62_ONE = 64'h4000000000000000;

   // command codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_LOG   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DIRECTION = 2'd0;
   localparam logic [1:0] CSR_LOG_FIRST  = 2'd1;
   localparam logic [1:0] CSR_LOG_SECOND = 2'd2;
   localparam logic [1:0] CSR_LOG_THIRD  = 2'd3;

   typedef logic signed [PART_WIDTH-1:0] part_type;
   typedef part_type [NUM_PARTS-1:0] elem_type;
   typedef logic signed [TW_W-1:0] tw_type;
   typedef logic [2*TW_MAG_W-1:0] tw_rom_type [ROM_DEPTH];

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] index;
      part_type          in_part0;
      part_type          in_part1;
      part_type          in_part2;
      part_type          in_part3;
      part_type          in_part4;
      part_type          in_part5;
      part_type          in_part6;
      part_type          in_part7;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      part_type   out_part0;
      part_type   out_part1;
      part_type   out_part2;
      part_type   out_part3;
      part_type   out_part4;
      part_type   out_part5;
      part_type   out_part6;
      part_type   out_part7;
   } rsp_type;

   // (a * b) >> 62, truncated to 64 bits
   function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // cos/sin of pi*m/2^11 for m up to an eighth of a turn, rounded to Q1.16
   function automatic tw_rom_type build_tw_rom();
      tw_rom_type  rom;
      logic [63:0] t, t2, ts, tc, ss, cs, rc, rs;
      for (int m = 0; m < ROM_DEPTH; m++) begin
         t  = mul62(PI_Q62, 64'(m) << (62 - TW_IDX_W));
         t2 = mul62(t, t);
         ts = t;
         ss = t;
         tc = Q62_ONE;
         cs = Q62_ONE;
         for (int k = 1; k <= 12; k++) begin
            ts = mul62(ts, t2) / 64'((2 * k) * (2 * k + 1));
            tc = mul62(tc, t2) / 64'((2 * k - 1) * (2 * k));
            if ((k & 1) == 1) begin
               ss = ss - ts;
               cs = cs - tc;
            end else begin
               ss = ss + ts;
               cs = cs + tc;
            end
         end
         rc = (cs + (64'd1 << (61 - TWIDDLE_FRAC))) >> (62 - TWIDDLE_FRAC);
         rs = (ss + (64'd1 << (61 - TWIDDLE_FRAC))) >> (62 - TWIDDLE_FRAC);
         rom[m] = {rc[TW_MAG_W-1:0], rs[TW_MAG_W-1:0]};
      end
      return rom;
   endfunction

   localparam tw_rom_type TW_ROM = build_tw_rom();

   function automatic part_type saturate(input logic signed [RES_W-1:0] v);
      logic [RES_W-PART_WIDTH:0] top;
      top = v[RES_W-1:PART_WIDTH-1];
      if (&top || ~|top) begin
         return v[PART_WIDTH-1:0];
      end
      return v[RES_W-1] ? {1'b1, {(PART_WIDTH-1){1'b0}}} : {1'b0, {(PART_WIDTH-1){1'b1}}};
   endfunction

endpackage

[src/hfft_store.sv]
// ----------------------------------------------------------------------------
// hfft_store
// Element memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hfft_store (
   input  logic                      clock,
   input  logic                      we,
   input  logic [hfft_pkg::ADDR_W-1:0] waddr,
   input  hfft_pkg::elem_type        wdata,
   input  logic                      re,
   input  logic [hfft_pkg::ADDR_W-1:0] raddr_a,
   input  logic [hfft_pkg::ADDR_W-1:0] raddr_b,
   output hfft_pkg::elem_type        q_a,
   output hfft_pkg::elem_type        q_b
);

   hfft_pkg::elem_type mem [hfft_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         q_a <= mem[raddr_a];
         q_b <= mem[raddr_b];
      end
   end

endmodule

[src/hfft_twiddle_rom.sv]
// ----------------------------------------------------------------------------
// hfft_twiddle_rom
// Eighth-wave twiddle table with octant folding and sign by direction.
// ----------------------------------------------------------------------------
module hfft_twiddle_rom (
   input  logic                          clock,
   input  logic                          re,
   input  logic [hfft_pkg::TW_IDX_W-1:0] tw_index,
   input  logic                          direction,
   output hfft_pkg::tw_type              wr,
   output hfft_pkg::tw_type              wi
);

   localparam int HALF    = 1 << (hfft_pkg::TW_IDX_W - 1);
   localparam int QUARTER = 1 << (hfft_pkg::TW_IDX_W - 2);

   logic [hfft_pkg::TW_IDX_W-1:0] fold;
   logic [hfft_pkg::ROM_AW-1:0]   rom_addr;
   logic                          neg, swap;
   logic [2*hfft_pkg::TW_MAG_W-1:0] entry_ff;
   logic                          neg_ff, swap_ff;
   logic [hfft_pkg::TW_MAG_W-1:0] c_mag, s_mag;
   hfft_pkg::tw_type              c_val, s_val;

   always_comb begin
      if (tw_index > hfft_pkg::TW_IDX_W'(HALF)) begin
         fold = hfft_pkg::TW_IDX_W'((HALF * 2) - int'(tw_index));
         neg  = 1'b1;
      end else begin
         fold = tw_index;
         neg  = 1'b0;
      end
      if (fold <= hfft_pkg::TW_IDX_W'(QUARTER)) begin
         rom_addr = fold[hfft_pkg::ROM_AW-1:0];
         swap     = 1'b0;
      end else begin
         rom_addr = hfft_pkg::ROM_AW'(HALF - int'(fold));
         swap     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         entry_ff <= hfft_pkg::TW_ROM[rom_addr];
         neg_ff   <= neg;
         swap_ff  <= swap;
      end
   end

   // entry holds {cos, sin}; past the octant the two trade places
   assign c_mag = swap_ff ? entry_ff[hfft_pkg::TW_MAG_W-1:0]
                          : entry_ff[2*hfft_pkg::TW_MAG_W-1:hfft_pkg::TW_MAG_W];
   assign s_mag = swap_ff ? entry_ff[2*hfft_pkg::TW_MAG_W-1:hfft_pkg::TW_MAG_W]
                          : entry_ff[hfft_pkg::TW_MAG_W-1:0];
   assign c_val = hfft_pkg::tw_type'({1'b0, c_mag});
   assign s_val = hfft_pkg::tw_type'({1'b0, s_mag});
   assign wr    = neg_ff ? -c_val : c_val;
   assign wi    = direction ? s_val : -s_val;

endmodule

[src/hfft_bfly.sv]
// ----------------------------------------------------------------------------
// hfft_bfly
// Hypercomplex butterfly datapath: multiply, round, add/subtract, saturate.
// ----------------------------------------------------------------------------
module hfft_bfly (
   input  logic               clock,
   input  hfft_pkg::elem_type x,
   input  hfft_pkg::elem_type z,
   input  hfft_pkg::tw_type   wr,
   input  hfft_pkg::tw_type   wi,
   input  logic [1:0]         dim,
   output hfft_pkg::elem_type res_i,
   output hfft_pkg::elem_type res_j
);

   logic signed [hfft_pkg::PROD_W-1:0] m1 [hfft_pkg::NUM_PARTS];
   logic signed [hfft_pkg::PROD_W-1:0] m2 [hfft_pkg::NUM_PARTS];
   logic signed [hfft_pkg::PROD_W-1:0] m1_ff [hfft_pkg::NUM_PARTS];
   logic signed [hfft_pkg::PROD_W-1:0] m2_ff [hfft_pkg::NUM_PARTS];
   logic signed [hfft_pkg::WD_W-1:0]   wd_ff [hfft_pkg::NUM_PARTS];
   logic [2:0] unit_mask;

   assign unit_mask = 3'b001 << dim;

   always_comb begin
      logic [2:0]       partner;
      hfft_pkg::tw_type wsel;
      for (int p = 0; p < hfft_pkg::NUM_PARTS; p++) begin
         partner = 3'(p) ^ unit_mask;
         wsel    = ((3'(p) & unit_mask) != 3'd0) ? wi : -wi;
         m1[p]   = hfft_pkg::PROD_W'(wr) * hfft_pkg::PROD_W'(z[p]);
         m2[p]   = hfft_pkg::PROD_W'(wsel) * hfft_pkg::PROD_W'(z[partner]);
      end
   end

   always_ff @(posedge clock) begin
      logic signed [hfft_pkg::SUM_W-1:0] acc;
      for (int p = 0; p < hfft_pkg::NUM_PARTS; p++) begin
         m1_ff[p] <= m1[p];
         m2_ff[p] <= m2[p];
         acc = hfft_pkg::SUM_W'(m1_ff[p]) + hfft_pkg::SUM_W'(m2_ff[p])
             + hfft_pkg::SUM_W'(1 << (hfft_pkg::TWIDDLE_FRAC - 1));
         wd_ff[p] <= acc[hfft_pkg::SUM_W-1:hfft_pkg::TWIDDLE_FRAC];
         res_i[p] <= hfft_pkg::saturate(hfft_pkg::RES_W'(x[p]) + hfft_pkg::RES_W'(wd_ff[p]));
         res_j[p] <= hfft_pkg::saturate(hfft_pkg::RES_W'(x[p]) - hfft_pkg::RES_W'(wd_ff[p]));
      end
   end

endmodule

[src/hypercomplex_fft_3d_unit.sv]
// ----------------------------------------------------------------------------
// hypercomplex_fft_3d_unit
// In-place radix-2 FFT over a 3-D array of eight-part hypercomplex elements.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  handshake
//  req       start, busy, req_item            in         start && !busy
//  rsp       rsp_valid, rsp_item              out        one-cycle strobe
//  csr       csr_valid, csr_ready, index/data in         valid && ready
//
//  Write, read and idle items do not raise busy; the response is registered
//  and follows in the cycle after the item (the element read comes from the
//  registered port). A run holds busy through a closing state, and its
//  response comes as busy falls. Each butterfly steps through address, read,
//  multiply, round, add and write-back states, and the pair is written one
//  entry at a time through the single memory write port.
//  Reset is synchronous; the element store is not cleared.
//  Responses cannot be held off; csr is always ready.
// ----------------------------------------------------------------------------
module hypercomplex_fft_3d_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hfft_pkg::req_type req_item,
   output logic              rsp_valid,
   output hfft_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIM  = 4'd1;
   localparam logic [3:0] ST_REV  = 4'd2;
   localparam logic [3:0] ST_BFLY = 4'd3;
   localparam logic [3:0] ST_RD   = 4'd4;
   localparam logic [3:0] ST_MUL  = 4'd5;
   localparam logic [3:0] ST_SUM  = 4'd6;
   localparam logic [3:0] ST_ADD  = 4'd7;
   localparam logic [3:0] ST_WJ   = 4'd8;
   localparam logic [3:0] ST_WI   = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   localparam int AW = hfft_pkg::ADDR_W;

   // configuration
   logic                       dir_ff;
   logic [hfft_pkg::LOG_W-1:0] log1_ff, log2_ff, log3_ff;

   // sequencer
   logic [3:0]    state_ff, state_in;
   logic [1:0]    dim_ff, dim_in;
   logic [AW-1:0] line_ff, line_in;
   logic [AW-1:0] k_ff, k_in;            // reversal index, or butterfly number
   logic [3:0]    b_ff, b_in;            // butterfly pass
   logic          swap_ff, swap_in;
   logic [AW-1:0] addr_i_ff, addr_i_in, addr_j_ff, addr_j_in;
   logic [hfft_pkg::TW_IDX_W-1:0] tw_idx_ff, tw_idx_in;

   // response
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_rd_ff, rsp_rd_in;

   logic       accept;
   logic [5:0] total_log;
   logic       log_bad, range_bad;
   logic [hfft_pkg::LOG_W-1:0] len;
   logic [4:0]    lo;
   logic [AW-1:0] stride_mask, line_last, line_base, line_hi;
   logic [AW-1:0] k_last, q_last, k_rev, rev_full;
   logic [AW-1:0] dual, pos_a, pos_g, pos_i, pos_j;

   // memory and datapath
   logic               st_we, st_re;
   logic [AW-1:0]      st_waddr, st_raddr_a;
   hfft_pkg::elem_type st_wdata, q_a, q_b, res_i, res_j, req_elem;
   hfft_pkg::tw_type   wr, wi;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   assign total_log = 6'(log1_ff) + 6'(log2_ff) + 6'(log3_ff);
   assign log_bad   = total_log > 6'(hfft_pkg::MAX_LOG_TOTAL);
   assign range_bad = ((13'(req_item.index) >> total_log) != 13'd0);

   // geometry of the dimension in work
   always_comb begin
      unique case (dim_ff)
         2'd0:    begin len = log1_ff; lo = 5'd0;                      end
         2'd1:    begin len = log2_ff; lo = 5'(log1_ff);               end
         default: begin len = log3_ff; lo = 5'(log1_ff) + 5'(log2_ff); end
      endcase
   end

   assign stride_mask = AW'((13'd1 << lo) - 13'd1);
   assign line_last   = AW'((13'd1 << 6'(total_log - 6'(len))) - 13'd1);
   assign line_hi     = line_ff >> lo;
   assign line_base   = (line_ff & stride_mask) | (line_hi << (lo + 5'(len)));
   assign k_last      = AW'((13'd1 << len) - 13'd1);
   assign q_last      = AW'(((13'd1 << len) >> 1) - 13'd1);

   always_comb begin
      for (int t = 0; t < AW; t++) begin
         rev_full[t] = k_ff[AW-1-t];
      end
   end
   assign k_rev = rev_full >> (5'(AW) - 5'(len));

   // butterfly k of pass b: i = g + a, j = i + dual
   assign dual  = AW'(1) << b_ff;
   assign pos_a = k_ff & (dual - AW'(1));
   assign pos_g = (k_ff >> b_ff) << (b_ff + 4'd1);
   assign pos_i = pos_g | pos_a;
   assign pos_j = pos_i | dual;

   always_comb begin
      state_in      = state_ff;
      dim_in        = dim_ff;
      line_in       = line_ff;
      k_in          = k_ff;
      b_in          = b_ff;
      swap_in       = swap_ff;
      addr_i_in     = addr_i_ff;
      addr_j_in     = addr_j_ff;
      tw_idx_in     = tw_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rd_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.op) inside
                  hfft_pkg::OP_RUN: begin
                     if (log_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = hfft_pkg::STATUS_LOG;
                     end else begin
                        dim_in   = 2'd0;
                        state_in = ST_DIM;
                     end
                  end
                  hfft_pkg::OP_WRITE, hfft_pkg::OP_READ: begin
                     rsp_valid_in = 1'b1;
                     if (log_bad) begin
                        rsp_status_in = hfft_pkg::STATUS_LOG;
                     end else if (range_bad) begin
                        rsp_status_in = hfft_pkg::STATUS_RANGE;
                     end else begin
                        rsp_status_in = hfft_pkg::STATUS_OK;
                        rsp_rd_in     = req_item.op == hfft_pkg::OP_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = hfft_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_DIM: begin
            if (len == '0) begin
               if (dim_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  dim_in = dim_ff + 2'd1;
               end
            end else begin
               line_in  = '0;
               k_in     = '0;
               state_in = ST_REV;
            end
         end
         ST_REV: begin
            addr_i_in = line_base | (k_ff << lo);
            addr_j_in = line_base | (k_rev << lo);
            swap_in   = 1'b1;
            if (k_ff < k_rev) begin
               state_in = ST_RD;
            end else if (k_ff == k_last) begin
               k_in     = '0;
               b_in     = '0;
               state_in = ST_BFLY;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_BFLY: begin
            addr_i_in = line_base | (pos_i << lo);
            addr_j_in = line_base | (pos_j << lo);
            tw_idx_in = hfft_pkg::TW_IDX_W'(pos_a << (4'(hfft_pkg::TW_IDX_W) - b_ff));
            swap_in   = 1'b0;
            state_in  = ST_RD;
         end
         ST_RD:  state_in = swap_ff ? ST_WJ : ST_MUL;
         ST_MUL: state_in = ST_SUM;
         ST_SUM: state_in = ST_ADD;
         ST_ADD: state_in = ST_WJ;
         ST_WJ:  state_in = ST_WI;
         ST_WI: begin
            if (swap_ff) begin
               if (k_ff == k_last) begin
                  k_in     = '0;
                  b_in     = '0;
                  state_in = ST_BFLY;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_REV;
               end
            end else if (k_ff != q_last) begin
               k_in     = k_ff + AW'(1);
               state_in = ST_BFLY;
            end else begin
               k_in = '0;
               if (b_ff != len - 4'd1) begin
                  b_in     = b_ff + 4'd1;
                  state_in = ST_BFLY;
               end else if (line_ff != line_last) begin
                  line_in  = line_ff + AW'(1);
                  state_in = ST_REV;
               end else if (dim_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  dim_in   = dim_ff + 2'd1;
                  state_in = ST_DIM;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = hfft_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dim_ff        <= '0;
         line_ff       <= '0;
         k_ff          <= '0;
         b_ff          <= '0;
         swap_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= hfft_pkg::STATUS_OK;
         rsp_rd_ff     <= 1'b0;
         dir_ff        <= 1'b0;
         log1_ff       <= '0;
         log2_ff       <= '0;
         log3_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         dim_ff        <= dim_in;
         line_ff       <= line_in;
         k_ff          <= k_in;
         b_ff          <= b_in;
         swap_ff       <= swap_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_rd_ff     <= rsp_rd_in;
         if (csr_valid) begin
            unique case (csr_index)
               hfft_pkg::CSR_DIRECTION:  dir_ff  <= csr_data[0];
               hfft_pkg::CSR_LOG_FIRST:  log1_ff <= csr_data;
               hfft_pkg::CSR_LOG_SECOND: log2_ff <= csr_data;
               hfft_pkg::CSR_LOG_THIRD:  log3_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // pair addresses and twiddle index: payload, no reset
   always_ff @(posedge clock) begin
      addr_i_ff <= addr_i_in;
      addr_j_ff <= addr_j_in;
      tw_idx_ff <= tw_idx_in;
   end

   assign req_elem = {req_item.in_part7, req_item.in_part6, req_item.in_part5,
                      req_item.in_part4, req_item.in_part3, req_item.in_part2,
                      req_item.in_part1, req_item.in_part0};

   // memory ports: commands in idle, swap/butterfly traffic otherwise
   always_comb begin
      st_we    = 1'b0;
      st_waddr = req_item.index;
      st_wdata = req_elem;
      if (state_ff == ST_IDLE) begin
         st_we = accept && req_item.op == hfft_pkg::OP_WRITE && !log_bad && !range_bad;
      end else if (state_ff == ST_WJ) begin
         st_we    = 1'b1;
         st_waddr = addr_j_ff;
         st_wdata = swap_ff ? q_a : res_j;
      end else if (state_ff == ST_WI) begin
         st_we    = 1'b1;
         st_waddr = addr_i_ff;
         st_wdata = swap_ff ? q_b : res_i;
      end
   end

   assign st_re = (state_ff == ST_RD) ||
                  (accept && req_item.op == hfft_pkg::OP_READ && !log_bad && !range_bad);
   assign st_raddr_a = (state_ff == ST_RD) ? addr_i_ff : req_item.index;

   hfft_store u_store (
      .clock   (clock),
      .we      (st_we),
      .waddr   (st_waddr),
      .wdata   (st_wdata),
      .re      (st_re),
      .raddr_a (st_raddr_a),
      .raddr_b (addr_j_ff),
      .q_a     (q_a),
      .q_b     (q_b)
   );

   hfft_twiddle_rom u_rom (
      .clock     (clock),
      .re        (state_ff == ST_RD),
      .tw_index  (tw_idx_ff),
      .direction (dir_ff),
      .wr        (wr),
      .wi        (wi)
   );

   hfft_bfly u_bfly (
      .clock (clock),
      .x     (q_a),
      .z     (q_b),
      .wr    (wr),
      .wi    (wi),
      .dim   (dim_ff),
      .res_i (res_i),
      .res_j (res_j)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item.status    = rsp_status_ff;
   assign rsp_item.out_part0 = rsp_rd_ff ? q_a[0] : '0;
   assign rsp_item.out_part1 = rsp_rd_ff ? q_a[1] : '0;
   assign rsp_item.out_part2 = rsp_rd_ff ? q_a[2] : '0;
   assign rsp_item.out_part3 = rsp_rd_ff ? q_a[3] : '0;
   assign rsp_item.out_part4 = rsp_rd_ff ? q_a[4] : '0;
   assign rsp_item.out_part5 = rsp_rd_ff ? q_a[5] : '0;
   assign rsp_item.out_part6 = rsp_rd_ff ? q_a[6] : '0;
   assign rsp_item.out_part7 = rsp_rd_ff ? q_a[7] : '0;

`ifndef SYNTH
   // a valid run item raises busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.op == hfft_pkg::OP_RUN && !log_bad |=> busy)
      else $error("run item did not start the sequencer");

   // a pair never names one entry twice
   a_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD |-> addr_i_ff != addr_j_ff)
      else $error("butterfly or swap pair aliases one entry");

   // no write while the pair is in flight in the datapath
   a_no_write_mid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_MUL || state_ff == ST_SUM ||
       state_ff == ST_ADD) |-> !st_we)
      else $error("store written while pair in flight");

   // every response follows an item or the end of a run
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept) || $past(state_ff == ST_DONE))
      else $error("response without cause");
`endif

endmodule
